### src/nsi_pkg.sv
package nsi_pkg;

  localparam int FIELD_W = 32;

  // Item codes.
  localparam logic [2:0] OP_RESTART = 3'd0;
  localparam logic [2:0] OP_ADVANCE = 3'd1;
  localparam logic [2:0] OP_COMMIT  = 3'd2;
  localparam logic [2:0] OP_CANCEL  = 3'd3;
  localparam logic [2:0] OP_UPDATE  = 3'd4;
  localparam logic [2:0] OP_PREDICT = 3'd5;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_ORDER     = 3'd0;
  localparam logic [2:0] REG_TIME_STEP = 3'd1;
  localparam logic [2:0] REG_INV_STEP  = 3'd2;
  localparam logic [2:0] REG_INV_GAMMA = 3'd3;
  localparam logic [2:0] REG_GAMMA_RAT = 3'd4;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [FIELD_W-1:0] disp_new;
    logic signed [FIELD_W-1:0] disp_old;
    logic signed [FIELD_W-1:0] vel_old;
    logic signed [FIELD_W-1:0] acc_old;
  } nsi_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] disp_out;
    logic signed [FIELD_W-1:0] vel_out;
    logic signed [FIELD_W-1:0] acc_out;
    logic                      coeff_change;
    logic [FIELD_W-1:0]        step_now;
  } nsi_out_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic start;
    logic half;   // scale by one extra bit (the 0.5 dt product)
  } nsi_mul_ctl_t;

endpackage

### src/nsi_if.sv
interface nsi_in_if;
  import nsi_pkg::*;
  logic    valid;
  logic    ready;
  nsi_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nsi_out_if;
  import nsi_pkg::*;
  logic     valid;
  logic     ready;
  nsi_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/nsi_mul.sv
module nsi_mul #(
  parameter int IW   = 32,
  parameter int DW   = 32,
  parameter int FRAC = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nsi_pkg::nsi_mul_ctl_t         ctl,
  input  logic signed [IW-1:0]          x,
  input  logic signed [nsi_pkg::FIELD_W-1:0] y,
  output logic                          done,
  output logic signed [IW-1:0]          res
);
  import nsi_pkg::*;

  localparam int NCH = (IW + 31) / 32;
  localparam int XW  = NCH * 32;
  localparam int PRW = XW + 32;
  localparam int PW  = PRW + 2;
  localparam int CW  = $clog2(NCH + 1);
  localparam logic signed [PW-1:0] SMAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = ~SMAX;

  logic              neg;
  logic              half_r;
  logic [XW-1:0]     ux;
  logic [31:0]       uy;
  logic [PRW-1:0]    prod;
  logic [CW-1:0]     cnt;
  logic              fin;
  logic [IW-1:0]     ax;
  logic [31:0]       ay;
  logic [63:0]       pp;
  logic signed [PW-1:0] sp;
  logic signed [PW-1:0] rounded;
  logic signed [PW-1:0] shifted;

  assign ax = x[IW-1] ? IW'(-x) : IW'(x);
  assign ay = y[31] ? 32'(-y) : 32'(y);

  // One 32 by 32 slice a cycle, most significant slice of the magnitude first.
  assign pp = {32'b0, ux[XW-1 -: 32]} * {32'b0, uy};

  // Sign, round half up, scale and saturate the finished magnitude.
  always_comb begin
    sp      = neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
    rounded = sp + (half_r ? (PW'(1) << FRAC) : (PW'(1) << (FRAC - 1)));
    shifted = half_r ? (rounded >>> (FRAC + 1)) : (rounded >>> FRAC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (ctl.start) begin
        neg    <= x[IW-1] ^ y[31];
        half_r <= ctl.half;
        ux     <= XW'(ax);
        uy     <= ay;
        prod   <= '0;
        cnt    <= CW'(NCH);
      end else if (cnt != '0) begin
        prod <= (prod << 32) + PRW'(pp);
        ux   <= ux << 32;
        cnt  <= cnt - 1'b1;
        fin  <= (cnt == CW'(1));
      end
      if (fin) begin
        if (shifted > SMAX) begin
          res <= IW'(SMAX);
        end else if (shifted < SMIN) begin
          res <= IW'(SMIN);
        end else begin
          res <= IW'(shifted);
        end
      end
    end
  end

endmodule

### src/newmark_state_integrator.sv
// Control items (restart, advance, commit, cancel and the unused codes) go straight to the output stage.
// Element items issue multiplies to the shared unit, each working through N = ceil(max(32,DATA_WIDTH)/32)
// 32-bit slices; update needs 1, 2 or 4 multiplies, predict 1 or 2.
// One item at a time: a new item is taken only once the previous result is in the output register,
// so output stalls hold off the next item.
// Synchronous active-high reset clears the step counters and loads the coefficient defaults.
module newmark_state_integrator #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  nsi_in_if.sink                       item,
  nsi_out_if.source                    result
);
  import nsi_pkg::*;

  // Internal values are at least as wide as the 32-bit fields, since inputs
  // reach some results unsaturated; every arithmetic result is saturated to
  // DATA_WIDTH bits signed.
  localparam int IW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam logic signed [IW:0] AMAX = {{(IW-DATA_WIDTH+2){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [IW:0] AMIN = ~AMAX;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  // Micro-steps: each one issues a single multiply to the shared unit.
  localparam logic [2:0] PH_UV1 = 3'd0;  // (u - u0) * coefficient
  localparam logic [2:0] PH_UV2 = 3'd1;  // v0 * gamma ratio, then v
  localparam logic [2:0] PH_UA1 = 3'd2;  // (v - v0) * coefficient
  localparam logic [2:0] PH_UA2 = 3'd3;  // a0 * gamma ratio, then a
  localparam logic [2:0] PH_PV  = 3'd4;  // dt * a0, then v
  localparam logic [2:0] PH_PD  = 3'd5;  // 0.5 dt * (v0 + v), then u

  // Configuration registers.
  logic [1:0]         deriv_order;
  logic signed [31:0] time_step;
  logic signed [31:0] inv_time_step;
  logic signed [31:0] inv_gamma_step;
  logic signed [31:0] gamma_ratio;

  // Step counters.
  logic [31:0] step_count;
  logic [31:0] committed_step;
  logic [31:0] adv_count;

  // Sequencer and datapath registers.
  logic [1:0]         state;
  logic [2:0]         phase;
  logic               first;
  logic               chg;
  logic signed [IW-1:0] u_r, u0_r, v0_r, a0_r;
  logic signed [IW-1:0] dreg, vreg, areg, tmp;

  // Output register.
  logic     res_valid;
  nsi_out_t res;

  // Shared adder and multiplier.
  logic signed [IW-1:0] add_a, add_b, add_res;
  logic                 add_sub;
  logic signed [IW:0]   add_sum;
  nsi_mul_ctl_t         mul_ctl;
  logic signed [IW-1:0] mul_x, mul_res;
  logic signed [31:0]   mul_y;
  logic                 mul_done;
  logic                 second;
  logic                 cfg_wr;
  logic                 accept;
  logic                 load_out;

  assign second  = deriv_order[1];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign accept  = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);

  // Configuration port: writes land at the access cycle; reads are combinational.
  always_ff @(posedge clk) begin
    if (rst) begin
      deriv_order    <= 2'd1;
      time_step      <= 32'sd65536;
      inv_time_step  <= 32'sd65536;
      inv_gamma_step <= 32'sd131072;
      gamma_ratio    <= -32'sd65536;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ORDER:     deriv_order    <= pwdata[1:0];
        REG_TIME_STEP: time_step      <= pwdata;
        REG_INV_STEP:  inv_time_step  <= pwdata;
        REG_INV_GAMMA: inv_gamma_step <= pwdata;
        REG_GAMMA_RAT: gamma_ratio    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ORDER:     prdata = {30'b0, deriv_order};
      REG_TIME_STEP: prdata = time_step;
      REG_INV_STEP:  prdata = inv_time_step;
      REG_INV_GAMMA: prdata = inv_gamma_step;
      REG_GAMMA_RAT: prdata = gamma_ratio;
      default:       prdata = 32'b0;
    endcase
  end

  // The single adder serves two purposes: while a multiply is being issued it
  // forms the difference or sum that feeds it, and when the multiply returns
  // it folds the product into the running value. Both results saturate.
  always_comb begin
    add_a   = u_r;
    add_b   = u0_r;
    add_sub = 1'b1;
    if (state == S_ISSUE) begin
      case (phase)
        PH_UA1: begin
          add_a = vreg;
          add_b = v0_r;
        end
        PH_PD: begin
          add_a   = v0_r;
          add_b   = vreg;
          add_sub = 1'b0;
        end
        default: ;
      endcase
    end else begin
      add_sub = 1'b0;
      add_b   = mul_res;
      case (phase)
        PH_PV:   add_a = v0_r;
        PH_PD:   add_a = u0_r;
        default: add_a = tmp;
      endcase
    end
  end

  assign add_sum = add_sub ? ({add_a[IW-1], add_a} - {add_b[IW-1], add_b})
                           : ({add_a[IW-1], add_a} + {add_b[IW-1], add_b});

  always_comb begin
    if (add_sum > AMAX) begin
      add_res = IW'(AMAX);
    end else if (add_sum < AMIN) begin
      add_res = IW'(AMIN);
    end else begin
      add_res = IW'(add_sum);
    end
  end

  // Multiplier operands for the current micro-step. The first step of a run
  // (step count of one or less) uses 1/dt, later steps 1/(gamma dt).
  always_comb begin
    mul_ctl.start = (state == S_ISSUE);
    mul_ctl.half  = (phase == PH_PD);
    mul_x         = add_res;
    mul_y         = first ? inv_time_step : inv_gamma_step;
    case (phase)
      PH_UV2: begin
        mul_x = v0_r;
        mul_y = gamma_ratio;
      end
      PH_UA2: begin
        mul_x = a0_r;
        mul_y = gamma_ratio;
      end
      PH_PV: begin
        mul_x = a0_r;
        mul_y = time_step;
      end
      PH_PD:   mul_y = time_step;
      default: ;
    endcase
  end

  nsi_mul #(
    .IW   (IW),
    .DW   (DATA_WIDTH),
    .FRAC (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .x    (mul_x),
    .y    (mul_y),
    .done (mul_done),
    .res  (mul_res)
  );

  // Advance restarts from the committed copy and saturates at all ones.
  assign adv_count = committed_step + {31'b0, (committed_step != '1)};

  assign load_out = (state == S_OUT) && (!res_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_UV1;
      step_count     <= '0;
      committed_step <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            u_r   <= IW'(item.data.disp_new);
            u0_r  <= IW'(item.data.disp_old);
            v0_r  <= IW'(item.data.vel_old);
            a0_r  <= IW'(item.data.acc_old);
            first <= (step_count <= 32'd1);
            chg   <= 1'b0;
            dreg  <= '0;
            vreg  <= '0;
            areg  <= '0;
            state <= S_OUT;
            case (item.data.op)
              OP_RESTART: begin
                step_count     <= '0;
                committed_step <= '0;
                chg            <= 1'b1;
              end
              OP_ADVANCE: begin
                step_count <= adv_count;
                chg        <= (adv_count <= 32'd2);
              end
              OP_COMMIT: committed_step <= step_count;
              OP_CANCEL: begin
                step_count <= committed_step;
                chg        <= (committed_step < 32'd2);
              end
              OP_UPDATE: begin
                dreg  <= IW'(item.data.disp_new);
                phase <= PH_UV1;
                state <= S_ISSUE;
              end
              OP_PREDICT: begin
                // First order keeps v = v0; second order keeps a = a0.
                vreg  <= IW'(item.data.vel_old);
                areg  <= second ? IW'(item.data.acc_old) : '0;
                phase <= second ? PH_PV : PH_PD;
                state <= S_ISSUE;
              end
              default: ;
            endcase
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            state <= S_ISSUE;
            case (phase)
              PH_UV1: begin
                if (first) begin
                  vreg  <= mul_res;
                  phase <= PH_UA1;
                  if (!second) begin
                    state <= S_OUT;
                  end
                end else begin
                  tmp   <= mul_res;
                  phase <= PH_UV2;
                end
              end
              PH_UV2: begin
                vreg  <= add_res;
                phase <= PH_UA1;
                if (!second) begin
                  state <= S_OUT;
                end
              end
              PH_UA1: begin
                if (first) begin
                  areg  <= mul_res;
                  state <= S_OUT;
                end else begin
                  tmp   <= mul_res;
                  phase <= PH_UA2;
                end
              end
              PH_UA2: begin
                areg  <= add_res;
                state <= S_OUT;
              end
              PH_PV: begin
                vreg  <= add_res;
                phase <= PH_PD;
              end
              default: begin
                dreg  <= add_res;
                state <= S_OUT;
              end
            endcase
          end
        end
        default: begin
          // Hand the finished transaction to the output register once it is free.
          if (load_out) begin
            res.disp_out     <= dreg[31:0];
            res.vel_out      <= vreg[31:0];
            res.acc_out      <= areg[31:0];
            res.coeff_change <= chg;
            res.step_now     <= step_count;
            state            <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res;

  // The multiplier only answers a request that the sequencer is waiting on.
  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_WAIT)
    else $error("multiplier result arrived outside the wait state");

  // Control transactions go straight to the output stage.
  a_ctrl_to_out: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.data.op == OP_RESTART || item.data.op == OP_ADVANCE ||
                item.data.op == OP_COMMIT || item.data.op == OP_CANCEL)) |=> state == S_OUT)
    else $error("control transaction did not go to the output stage");

  // The committed copy changes only on restart or commit.
  a_commit_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && (item.data.op == OP_RESTART || item.data.op == OP_COMMIT))
      |=> $stable(committed_step))
    else $error("committed step changed without restart or commit");

  // A result handed over in the output stage is presented on the next cycle.
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> res_valid && state == S_IDLE)
    else $error("output register not loaded");

endmodule
